### hdl/indexed_list_engine_macros.svh
// Assertion helpers for the indexed list engine.
// They expect aclk and aresetn in scope.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// Holds on every clock edge outside reset.
`define ILE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define ILE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ILE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ile_pkg.sv
`default_nettype none

package ile_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

endpackage

`default_nettype wire

### hdl/ile_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module ile_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/indexed_list_engine.sv
`default_nettype none

// Channel  Direction  Beat contents
// s_       in         s_cmd, s_index, s_end_index, s_value
// m_       out        m_status, m_found_index, m_read_value, m_entry_count
//
// Append, write, insert at the tail, remove of the last entry, unused codes and
//   rejected commands finish from idle; read waits on the registered RAM read;
//   insert at i < n shifts entries up, then writes the new one; remove and search walk up.
//   The walk rate is set by the single entry RAM: one read and one write a cycle.
// Reset clears the sequencer state, count and result valid only; the entry RAM is not cleared.
// s_ready is high only when the sequencer is idle and the result slot is free
//   or being emptied; one command is in flight at a time.
// A stalled result holds the block until m_ready takes it.
module indexed_list_engine #(
    parameter int DEPTH = ile_pkg::DEPTH_DEF,
    parameter int WIDTH = ile_pkg::WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ile_pkg::CMD_W-1:0]     s_cmd,
    input  wire logic [ile_pkg::INDEX_W-1:0]   s_index,
    input  wire logic [ile_pkg::INDEX_W-1:0]   s_end_index,
    input  wire logic [ile_pkg::VALUE_W-1:0]   s_value,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [ile_pkg::STATUS_W-1:0]  m_status,
    output logic      [ile_pkg::INDEX_W-1:0]   m_found_index,
    output logic      [ile_pkg::VALUE_W-1:0]   m_read_value,
    output logic      [ile_pkg::COUNT_W-1:0]   m_entry_count
);

    // Address width, count width (holds DEPTH itself), and a compare width
    // wide enough for both the count and the 8-bit positions.
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > ile_pkg::INDEX_W) ? CW : ile_pkg::INDEX_W;

    // Sequencer: INS walks down copying entry p to p+1, PUT drops the new
    // entry in; REM walks up copying p to p-1; SRCH compares one entry a cycle.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_INS,
        ST_PUT,
        ST_REM,
        ST_SRCH
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [AW-1:0]                   pos_reg, pos_next;   // walk pointer
    logic [AW-1:0]                   lo_reg, lo_next;     // insert position
    logic [AW-1:0]                   hi_reg, hi_next;     // search end (exclusive)
    logic [WIDTH-1:0]                key_reg, key_next;   // insert data / search key
    logic                            m_valid_reg, m_valid_next;
    logic [ile_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [ile_pkg::INDEX_W-1:0]     found_reg, found_next;
    logic [ile_pkg::VALUE_W-1:0]     rdval_reg, rdval_next;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [WIDTH-1:0]                ram_wdata;
    logic [AW-1:0]                   ram_raddr;
    logic [WIDTH-1:0]                ram_rdata;

    logic                            s_fire;
    logic [CMPW-1:0]                 idx_w, end_w, cnt_w;
    logic                            is_full;
    logic [63:0]                     val64;
    logic [WIDTH-1:0]                val_w;
    logic [63:0]                     rd64;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;

    assign idx_w   = CMPW'(s_index);
    assign end_w   = CMPW'(s_end_index);
    assign cnt_w   = CMPW'(count_reg);
    assign is_full = (count_reg == CW'(DEPTH));

    // Data is taken to WIDTH bits: low bits when narrower, zero-filled when wider.
    assign val64 = {32'd0, s_value};
    assign val_w = val64[WIDTH-1:0];
    assign rd64  = 64'(ram_rdata);

    ile_ram #(
        .DATA_W (WIDTH),
        .DEPTH  (DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr  (ram_raddr),
        .rdata  (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        key_next     = key_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        found_next   = found_reg;
        rdval_next   = rdval_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    // Default: finish straight from idle with an OK beat.
                    status_next  = ile_pkg::STAT_OK;
                    found_next   = '0;
                    rdval_next   = '0;
                    m_valid_next = 1'b1;
                    unique case (s_cmd)
                        ile_pkg::CMD_APPEND: begin
                            if (is_full) begin
                                status_next = ile_pkg::STAT_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(count_reg);
                                ram_wdata  = val_w;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ile_pkg::CMD_READ: begin
                            if (idx_w < cnt_w) begin
                                ram_raddr    = AW'(idx_w);
                                state_next   = ST_READ;
                                m_valid_next = 1'b0;
                            end else begin
                                status_next = ile_pkg::STAT_RANGE;
                            end
                        end
                        ile_pkg::CMD_WRITE: begin
                            if (idx_w < cnt_w) begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(idx_w);
                                ram_wdata = val_w;
                            end else begin
                                status_next = ile_pkg::STAT_RANGE;
                            end
                        end
                        ile_pkg::CMD_INSERT: begin
                            if (idx_w > cnt_w) begin
                                status_next = ile_pkg::STAT_RANGE;
                            end else if (is_full) begin
                                status_next = ile_pkg::STAT_FULL;
                            end else if (idx_w == cnt_w) begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(idx_w);
                                ram_wdata  = val_w;
                                count_next = count_reg + 1'b1;
                            end else begin
                                key_next     = val_w;
                                lo_next      = AW'(idx_w);
                                pos_next     = AW'(count_reg - 1'b1);
                                ram_raddr    = AW'(count_reg - 1'b1);
                                state_next   = ST_INS;
                                m_valid_next = 1'b0;
                            end
                        end
                        ile_pkg::CMD_REMOVE: begin
                            if (idx_w >= cnt_w) begin
                                status_next = ile_pkg::STAT_RANGE;
                            end else if (idx_w == cnt_w - 1'b1) begin
                                count_next = count_reg - 1'b1;
                            end else begin
                                pos_next     = AW'(idx_w) + 1'b1;
                                ram_raddr    = AW'(idx_w) + 1'b1;
                                state_next   = ST_REM;
                                m_valid_next = 1'b0;
                            end
                        end
                        ile_pkg::CMD_SEARCH: begin
                            if ((idx_w < end_w) && (end_w < cnt_w)) begin
                                key_next     = val_w;
                                pos_next     = AW'(idx_w);
                                hi_next      = AW'(end_w);
                                ram_raddr    = AW'(idx_w);
                                state_next   = ST_SRCH;
                                m_valid_next = 1'b0;
                            end else begin
                                status_next = ile_pkg::STAT_RANGE;
                            end
                        end
                        default: begin
                            // unused codes: no change, OK beat
                        end
                    endcase
                end
            end
            ST_READ: begin
                rdval_next   = rd64[ile_pkg::VALUE_W-1:0];
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_INS: begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg + 1'b1;
                ram_wdata = ram_rdata;
                if (pos_reg == lo_reg) begin
                    state_next = ST_PUT;
                end else begin
                    pos_next  = pos_reg - 1'b1;
                    ram_raddr = pos_reg - 1'b1;
                end
            end
            ST_PUT: begin
                ram_we       = 1'b1;
                ram_waddr    = lo_reg;
                ram_wdata    = key_reg;
                count_next   = count_reg + 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_REM: begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg - 1'b1;
                ram_wdata = ram_rdata;
                if (CW'(pos_reg) == count_reg - 1'b1) begin
                    count_next   = count_reg - 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    pos_next  = pos_reg + 1'b1;
                    ram_raddr = pos_reg + 1'b1;
                end
            end
            ST_SRCH: begin
                if (ram_rdata == key_reg) begin
                    found_next   = ile_pkg::INDEX_W'(pos_reg);
                    status_next  = ile_pkg::STAT_OK;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else if (pos_reg + 1'b1 == hi_reg) begin
                    status_next  = ile_pkg::STAT_NOTFOUND;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    pos_next  = pos_reg + 1'b1;
                    ram_raddr = pos_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg    <= pos_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        rdval_reg  <= rdval_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_found_index = found_reg;
    assign m_read_value  = rdval_reg;
    assign m_entry_count = ile_pkg::COUNT_W'(count_reg);

    `include "indexed_list_engine_macros.svh"

    // count never runs past the store
    `ILE_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "count exceeds DEPTH")
    // no result beat is shown while a walk is in progress
    `ILE_ASSERT_IMP(a_busy_no_beat, state_reg != ST_IDLE, !m_valid_reg, "beat during walk")
    // count only moves when a command is taken or a walk ends
    `ILE_ASSERT_NXT(a_count_hold, state_reg == ST_IDLE && !s_fire, $stable(count_reg), "count moved")
    // insert walk stays inside the held entries
    `ILE_ASSERT_IMP(a_ins_pos, state_reg == ST_INS, CW'(pos_reg) < count_reg, "ins past count")
    `ILE_ASSERT_IMP(a_ins_lo, state_reg == ST_INS, lo_reg <= pos_reg, "ins below start")
    // a walk leaving busy always raises a result beat
    `ILE_ASSERT_NXT(a_walk_done, state_reg != ST_IDLE && state_next == ST_IDLE, m_valid_reg, "no beat")

endmodule

`default_nettype wire

### bench/indexed_list_engine_tb.sv
`default_nettype none

// Bench for indexed_list_engine.
//
// Stimulus is driven on the falling edge and everything is sampled on the
// rising edge. One monitor block sees both channels: every accepted command
// beat runs through the list predictor, which keeps its own copy of the
// entries and the count, and queues the reply it expects. Every accepted
// reply beat is checked field by field against the oldest queued reply.
//
// The stimulus generator reads the predictor's count and entries on the
// falling edge, after the last acceptance has been applied. It uses them to
// aim positions mostly inside the list, and search keys half the time at
// entries actually held, so that most commands do real work rather than
// bounce off the range checks.
module indexed_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Command codes that the block must ignore (reply ok, nothing changes).
    localparam logic [ile_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [ile_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    // Longest stretch with no beat on either channel. Covers a worst-case insert
    // walk plus sender gaps and reply stalls, with a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet time after the last reply, to catch a stray extra beat.
    localparam int END_QUIET = 300;

    typedef struct packed {
        logic [ile_pkg::STATUS_W-1:0] status;
        logic [ile_pkg::INDEX_W-1:0]  found_index;
        logic [ile_pkg::VALUE_W-1:0]  read_value;
        logic [ile_pkg::COUNT_W-1:0]  entry_count;
    } list_reply_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [ile_pkg::CMD_W-1:0]    s_cmd;
    logic [ile_pkg::INDEX_W-1:0]  s_index;
    logic [ile_pkg::INDEX_W-1:0]  s_end_index;
    logic [ile_pkg::VALUE_W-1:0]  s_value;
    logic                         m_valid;
    logic                         m_ready;
    logic [ile_pkg::STATUS_W-1:0] m_status;
    logic [ile_pkg::INDEX_W-1:0]  m_found_index;
    logic [ile_pkg::VALUE_W-1:0]  m_read_value;
    logic [ile_pkg::COUNT_W-1:0]  m_entry_count;

    // Predictor state: the list as the block should hold it.
    logic [ile_pkg::VALUE_W-1:0]  held_entries [ile_pkg::DEPTH_DEF];
    int unsigned                  held_count;

    list_reply_t                  pending_results [$];
    int unsigned                  mismatch_count;
    int unsigned                  reply_beats;
    int unsigned                  idle_cycles;

    // Throttling switches, flipped by the tests.
    bit                           sender_gaps;
    bit                           reply_stalls;

    indexed_list_engine i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_index       (s_index),
        .s_end_index   (s_end_index),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_index (m_found_index),
        .m_read_value  (m_read_value),
        .m_entry_count (m_entry_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one command to the held list, returns the reply.
    // ------------------------------------------------------------------
    function automatic list_reply_t apply_list_command(
        input logic [ile_pkg::CMD_W-1:0]   cmd,
        input logic [ile_pkg::INDEX_W-1:0] idx,
        input logic [ile_pkg::INDEX_W-1:0] stop,
        input logic [ile_pkg::VALUE_W-1:0] key
    );
        list_reply_t r;
        int unsigned i;
        r = '0;
        r.status = ile_pkg::STAT_OK;
        case (cmd)
            ile_pkg::CMD_APPEND: begin
                if (held_count >= ile_pkg::DEPTH_DEF) begin
                    r.status = ile_pkg::STAT_FULL;
                end else begin
                    held_entries[held_count] = key;
                    held_count++;
                end
            end
            ile_pkg::CMD_READ: begin
                if (idx < held_count) r.read_value = held_entries[idx];
                else r.status = ile_pkg::STAT_RANGE;
            end
            ile_pkg::CMD_WRITE: begin
                if (idx < held_count) held_entries[idx] = key;
                else r.status = ile_pkg::STAT_RANGE;
            end
            ile_pkg::CMD_INSERT: begin
                // position is checked before fullness
                if (idx > held_count) begin
                    r.status = ile_pkg::STAT_RANGE;
                end else if (held_count >= ile_pkg::DEPTH_DEF) begin
                    r.status = ile_pkg::STAT_FULL;
                end else begin
                    for (i = held_count; i > idx; i--) held_entries[i] = held_entries[i-1];
                    held_entries[idx] = key;
                    held_count++;
                end
            end
            ile_pkg::CMD_REMOVE: begin
                if (idx < held_count) begin
                    for (i = idx + 1; i < held_count; i++) held_entries[i-1] = held_entries[i];
                    held_count--;
                end else begin
                    r.status = ile_pkg::STAT_RANGE;
                end
            end
            ile_pkg::CMD_SEARCH: begin
                // end must stay strictly below the count
                if (idx < stop && stop < held_count) begin
                    r.status = ile_pkg::STAT_NOTFOUND;
                    for (i = idx; i < stop; i++) begin
                        if (r.status == ile_pkg::STAT_NOTFOUND && held_entries[i] == key) begin
                            r.status      = ile_pkg::STAT_OK;
                            r.found_index = ile_pkg::INDEX_W'(i);
                        end
                    end
                end else begin
                    r.status = ile_pkg::STAT_RANGE;
                end
            end
            default: ;
        endcase
        r.entry_count = ile_pkg::COUNT_W'(held_count);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on command beats, check on reply beats. The command
    // side goes first so a same-edge reply still finds its expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : beat_monitor
        list_reply_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_results.push_back(
                    apply_list_command(s_cmd, s_index, s_end_index, s_value));
            if (m_valid && m_ready) begin
                reply_beats++;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("reply beat %0d with nothing expected",
                                              reply_beats));
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch($sformatf("beat %0d status got %0d want %0d",
                                                  reply_beats, m_status, want.status));
                    if (m_found_index !== want.found_index)
                        report_mismatch($sformatf("beat %0d found_index got %0d want %0d",
                                                  reply_beats, m_found_index,
                                                  want.found_index));
                    if (m_read_value !== want.read_value)
                        report_mismatch($sformatf("beat %0d read_value got 0x%h want 0x%h",
                                                  reply_beats, m_read_value,
                                                  want.read_value));
                    if (m_entry_count !== want.entry_count)
                        report_mismatch($sformatf("beat %0d entry_count got %0d want %0d",
                                                  reply_beats, m_entry_count,
                                                  want.entry_count));
                end
            end
        end
    end

    // Watchdog: a long spell with no beat anywhere means the block is stuck.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("indexed_list_engine verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Reply side back-pressure: random stall bursts while enabled.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (reply_stalls && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. All of them are entered and left on a falling edge.
    // ------------------------------------------------------------------

    // One command beat. Valid stays up between back-to-back beats; it only
    // drops for a gap burst.
    task automatic send_command(
        input logic [ile_pkg::CMD_W-1:0]   cmd,
        input logic [ile_pkg::INDEX_W-1:0] idx,
        input logic [ile_pkg::INDEX_W-1:0] stop,
        input logic [ile_pkg::VALUE_W-1:0] key
    );
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_index     <= idx;
        s_end_index <= stop;
        s_value     <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Hold the sender off until every expected reply has been taken.
    task automatic wait_for_replies();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Data biased towards repeats, so first-match ordering gets tested.
    function automatic logic [ile_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return ile_pkg::VALUE_W'($urandom_range(1, 3));
            default: return ile_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    // One random command, mostly well placed for the current list.
    task automatic random_command();
        logic [ile_pkg::CMD_W-1:0]   cmd;
        logic [ile_pkg::INDEX_W-1:0] idx;
        logic [ile_pkg::INDEX_W-1:0] stop;
        logic [ile_pkg::VALUE_W-1:0] key;
        int unsigned                 roll;
        int unsigned                 n;
        n    = held_count;
        roll = $urandom_range(0, 99);
        idx  = ile_pkg::INDEX_W'($urandom);
        stop = ile_pkg::INDEX_W'($urandom);
        key  = pick_value();
        if (roll < 4) begin
            cmd = ile_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end else if (roll < 10) begin
            // noise: real command, wild positions
            cmd = ile_pkg::CMD_W'($urandom_range(ile_pkg::CMD_APPEND, ile_pkg::CMD_SEARCH));
        end else begin
            // keep the list short so walks stay cheap, but never empty for long
            if (n >= 40 && $urandom_range(0, 1) == 1)
                cmd = ile_pkg::CMD_REMOVE;
            else if (n < 3 && $urandom_range(0, 1) == 1)
                cmd = ile_pkg::CMD_APPEND;
            else
                cmd = ile_pkg::CMD_W'($urandom_range(ile_pkg::CMD_APPEND,
                                                     ile_pkg::CMD_SEARCH));
            case (cmd)
                ile_pkg::CMD_READ, ile_pkg::CMD_WRITE, ile_pkg::CMD_REMOVE: begin
                    idx = (n == 0) ? '0 : ile_pkg::INDEX_W'($urandom_range(0, n - 1));
                end
                ile_pkg::CMD_INSERT: begin
                    idx = ile_pkg::INDEX_W'($urandom_range(0, (n > 255) ? 255 : n));
                end
                ile_pkg::CMD_SEARCH: begin
                    if (n >= 2) begin
                        stop = ile_pkg::INDEX_W'($urandom_range(1, n - 1));
                        idx  = ile_pkg::INDEX_W'($urandom_range(0, stop - 1));
                        if ($urandom_range(0, 1) == 1)
                            key = held_entries[$urandom_range(0, n - 1)];
                    end
                end
                default: ;
            endcase
        end
        send_command(cmd, idx, stop, key);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short directed run from an empty list: range checks on every command,
    // insert at the tail, search bounds and a miss, the ignored codes.
    task automatic test_boundaries();
        send_command(ile_pkg::CMD_READ,   8'd0,   8'd0,   32'h0000_0000);  // empty: range
        send_command(ile_pkg::CMD_REMOVE, 8'd0,   8'd0,   32'h0000_0000);  // empty: range
        send_command(ile_pkg::CMD_INSERT, 8'd1,   8'd0,   32'h1234_5678);  // past the tail
        send_command(ile_pkg::CMD_INSERT, 8'd0,   8'd0,   32'hFFFF_FFFF);  // at count, empty
        send_command(ile_pkg::CMD_APPEND, 8'd255, 8'd255, 32'h0000_0000);
        send_command(ile_pkg::CMD_APPEND, 8'd0,   8'd0,   32'hA5A5_A5A5);
        send_command(ile_pkg::CMD_INSERT, 8'd3,   8'd0,   32'h5A5A_5A5A);  // index == count
        send_command(ile_pkg::CMD_INSERT, 8'd1,   8'd0,   32'h0000_0001);  // shifts three up
        send_command(ile_pkg::CMD_READ,   8'd0,   8'd0,   32'h0000_0000);
        send_command(ile_pkg::CMD_READ,   8'd4,   8'd0,   32'h0000_0000);  // last entry
        send_command(ile_pkg::CMD_READ,   8'd5,   8'd0,   32'h0000_0000);  // one past: range
        send_command(ile_pkg::CMD_READ,   8'd255, 8'd0,   32'h0000_0000);
        send_command(ile_pkg::CMD_WRITE,  8'd4,   8'd0,   32'h8000_0000);
        send_command(ile_pkg::CMD_WRITE,  8'd5,   8'd0,   32'h7FFF_FFFF);  // range
        send_command(ile_pkg::CMD_SEARCH, 8'd0,   8'd4,   32'h0000_0001);  // end at count-1
        send_command(ile_pkg::CMD_SEARCH, 8'd0,   8'd5,   32'h0000_0001);  // end == count
        send_command(ile_pkg::CMD_SEARCH, 8'd2,   8'd2,   32'h0000_0000);  // empty range
        send_command(ile_pkg::CMD_SEARCH, 8'd3,   8'd1,   32'h0000_0000);  // start past end
        send_command(ile_pkg::CMD_SEARCH, 8'd2,   8'd4,   32'hFFFF_FFFF);  // miss
        send_command(ile_pkg::CMD_SEARCH, 8'd0,   8'd255, 32'h0000_0000);  // end far out
        send_command(ile_pkg::CMD_SEARCH, 8'd0,   8'd1,   32'hFFFF_FFFF);  // hit at 0
        send_command(ile_pkg::CMD_REMOVE, 8'd0,   8'd0,   32'h0000_0000);
        send_command(ile_pkg::CMD_REMOVE, 8'd3,   8'd0,   32'h0000_0000);  // last entry
        send_command(ile_pkg::CMD_REMOVE, 8'd255, 8'd0,   32'h0000_0000);
        send_command(CMD_UNUSED_LO, 8'd255, 8'd255, 32'hFFFF_FFFF);
        send_command(CMD_UNUSED_HI, 8'd0,   8'd0,   32'h0000_0000);
    endtask

    // Fill to DEPTH and poke the full store: longest walks, edges of the store.
    task automatic test_full_store();
        while (held_count < ile_pkg::DEPTH_DEF)
            send_command(ile_pkg::CMD_APPEND, ile_pkg::INDEX_W'($urandom),
                         ile_pkg::INDEX_W'($urandom), pick_value());
        send_command(ile_pkg::CMD_APPEND, 8'd0,   8'd0,   32'hDEAD_BEEF);  // full
        send_command(ile_pkg::CMD_INSERT, 8'd0,   8'd0,   32'hDEAD_BEEF);  // full
        send_command(ile_pkg::CMD_INSERT, 8'd255, 8'd0,   32'hDEAD_BEEF);  // full
        send_command(ile_pkg::CMD_READ,   8'd255, 8'd0,   32'h0000_0000);
        send_command(ile_pkg::CMD_WRITE,  8'd255, 8'd0,   32'hC0DE_0001);
        send_command(ile_pkg::CMD_SEARCH, 8'd0,   8'd255, held_entries[254]);  // longest walk
        send_command(ile_pkg::CMD_SEARCH, 8'd0,   8'd255, 32'hC0DE_0001);  // last slot outside
        send_command(ile_pkg::CMD_SEARCH, 8'd254, 8'd255, held_entries[254]);
        send_command(ile_pkg::CMD_REMOVE, 8'd0,   8'd0,   32'h0000_0000);
        send_command(ile_pkg::CMD_INSERT, 8'd0,   8'd0,   32'h0BAD_F00D);  // back to full
        send_command(ile_pkg::CMD_REMOVE, 8'd255, 8'd0,   32'h0000_0000);
        send_command(ile_pkg::CMD_INSERT, 8'd255, 8'd0,   32'hFEED_0255);  // at the tail
        send_command(ile_pkg::CMD_READ,   8'd0,   8'd0,   32'h0000_0000);
    endtask

    // Main random run in segments with different throttling; one full
    // pause on the sender side partway through.
    task automatic test_random_traffic();
        int seg;
        int k;
        for (seg = 0; seg < 4; seg++) begin
            sender_gaps  = (seg != 1);
            reply_stalls = (seg != 2);
            for (k = 0; k < 40; k++) random_command();
            if (seg == 1) wait_for_replies();
        end
    endtask

    // Full rate on both sides from here to the end of the run.
    task automatic test_unthrottled_tail();
        int k;
        sender_gaps  = 1'b0;
        reply_stalls = 1'b0;
        for (k = 0; k < 20; k++) random_command();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_cmd          = '0;
        s_index        = '0;
        s_end_index    = '0;
        s_value        = '0;
        held_count     = 0;
        mismatch_count = 0;
        reply_beats    = 0;
        idle_cycles    = 0;
        sender_gaps    = 1'b1;
        reply_stalls   = 1'b1;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_boundaries();
        test_random_traffic();
        test_unthrottled_tail();
        test_full_store();

        wait_for_replies();
        repeat (END_QUIET) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", pending_results.size()));
        if (mismatch_count == 0) begin
            $display("indexed_list_engine verification clean");
        end else begin
            $display("indexed_list_engine verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
